>>> rtl/core/base64_stream_codec_unit_assert.svh
// Assertion macros used by the checker of the base64 stream codec.
`ifndef BASE64_STREAM_CODEC_UNIT_ASSERT_SVH
`define BASE64_STREAM_CODEC_UNIT_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define B64SC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define B64SC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/b64sc_pkg.sv
// Types, constants and character tables shared by the base64 stream codec.
`default_nettype none
package b64sc_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_DECODE_MODE = 1'b0;
  localparam logic REG_SKIP_LF     = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  // Characters with a special meaning.
  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Alphabet; entry 0 sits in the most significant byte.
  localparam logic [0:63][7:0] ENC_TABLE =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] in_value;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic decode_mode;
    logic skip_line_breaks;
  } cfg_regs_t;

  // One register write from the configuration port.
  typedef struct packed {
    logic en;
    logic index;
    logic value;
  } cfg_wr_t;

  // One group of results: up to four values, index of the final one,
  // end of message flag and a status shared by the whole group.
  typedef struct packed {
    logic [3:0][7:0] vals;
    logic [1:0]      last_idx;
    logic            last;
    logic [1:0]      status;
  } cmd_t;

  // Classification of one character in decode mode.
  typedef struct packed {
    logic [5:0] sextet;
    logic       is_pad;
    logic       is_bad;
  } sextet_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    return ENC_TABLE[s];
  endfunction

  function automatic sextet_t dec_sextet(input logic [7:0] c);
    sextet_t r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      r.sextet = 6'd63;
    end else if (c == CHAR_PAD) begin
      r.is_pad = 1'b1;
    end else begin
      r.is_bad = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/base64_stream_codec_unit.sv
// Top level of the base64 stream codec: configuration port and the three parts.
//
// Base64 (RFC 4648) codec on a byte stream. Register 0 (address 0) selects
// decoding, register 1 (address 4) makes the decoder ignore line feeds; any
// register write drops a partial group. The front part takes one item per
// cycle while the queue is not full and turns each complete group (or the
// end of a message) into a group of results, which waits in a two-entry
// queue; the back part sends those results one per cycle while the receiver
// is ready. Output bandwidth limits encoding, which makes four characters of
// every three bytes; decoding takes one character per cycle. A result group
// passes through a queue entry and the back part's group register on its way out.
`default_nettype none
module base64_stream_codec_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire b64sc_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output b64sc_pkg::out_item_t      out_data
);

  b64sc_pkg::cfg_wr_t   cfg_wr;
  b64sc_pkg::cfg_regs_t cfg_regs;
  b64sc_pkg::cmd_t      push_cmd;
  b64sc_pkg::cmd_t      head;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_nonempty;

  // Register access: words at byte addresses 0 and 4.
  assign pready       = 1'b1;
  assign cfg_wr.en    = psel && penable && pwrite;
  assign cfg_wr.index = paddr[2];
  assign cfg_wr.value = pwdata[0];
  assign prdata       = (paddr[2] == b64sc_pkg::REG_DECODE_MODE) ?
                        {31'd0, cfg_regs.decode_mode} :
                        {31'd0, cfg_regs.skip_line_breaks};

  b64sc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_regs (cfg_regs),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  b64sc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (head)
  );

  b64sc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/core/b64sc_front.sv
// Front part: takes items, gathers groups and quartets, queues result groups.
`default_nettype none
module b64sc_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire b64sc_pkg::cfg_wr_t  cfg_wr,
  output b64sc_pkg::cfg_regs_t     cfg_regs,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire b64sc_pkg::in_item_t in_data,
  input  wire logic                q_full,
  output logic                     q_push,
  output b64sc_pkg::cmd_t          q_cmd
);

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [1:0]  pad_count, pad_count_next;
  logic        bad_char_seen, bad_char_seen_next;

  logic                accept;
  logic [23:0]         enc_shift;
  logic [1:0]          enc_count;
  logic [23:0]         enc_bits;
  logic [2:0]          nchar;
  b64sc_pkg::sextet_t  dec;
  logic [5:0]          sext;
  logic [23:0]         dec_bits;
  logic [1:0]          pad_n;
  logic                bad_n;
  logic                bad_fin;
  logic [1:0]          nbytes_m1;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Group update and result group for the item on the input.
  always_comb begin
    group_bits_next    = group_bits;
    group_count_next   = group_count;
    pad_count_next     = pad_count;
    bad_char_seen_next = bad_char_seen;
    q_push             = 1'b0;
    q_cmd              = '0;
    enc_shift          = {group_bits[15:0], in_data.in_value};
    enc_count          = group_count + 2'd1;
    enc_bits           = enc_shift;
    nchar              = 3'd4;
    dec                = b64sc_pkg::dec_sextet(in_data.in_value);
    sext               = dec.is_bad ? 6'd0 : dec.sextet;
    dec_bits           = {group_bits[17:0], sext};
    pad_n              = 2'd0;
    bad_n              = bad_char_seen;
    bad_fin            = 1'b0;
    nbytes_m1          = 2'd2;

    if (dec.is_pad) begin
      pad_n = (pad_count == 2'd3) ? 2'd3 : pad_count + 2'd1;
    end else begin
      bad_n = bad_char_seen || dec.is_bad || (pad_count != 2'd0);
    end

    if (accept) begin
      if (!cfg_regs.decode_mode) begin
        // Encode: three bytes make four characters; a partial group at the
        // end of the message is zero filled and padded.
        if (enc_count == 2'd2) begin
          enc_bits = {enc_shift[15:0], 8'd0};
          nchar    = 3'd3;
        end else if (enc_count == 2'd1) begin
          enc_bits = {enc_shift[7:0], 16'd0};
          nchar    = 3'd2;
        end
        if (enc_count == 2'd3 || in_data.in_last) begin
          q_push = 1'b1;
          for (int i = 0; i < 4; i++) begin
            q_cmd.vals[i] = (3'(i) < nchar) ?
                            b64sc_pkg::enc_char(enc_bits[(18 - 6 * i) +: 6]) :
                            b64sc_pkg::CHAR_PAD;
          end
          q_cmd.last_idx     = 2'd3;
          q_cmd.last         = in_data.in_last;
          q_cmd.status       = b64sc_pkg::STATUS_OK;
          group_bits_next    = '0;
          group_count_next   = '0;
          pad_count_next     = '0;
          bad_char_seen_next = 1'b0;
        end else begin
          group_bits_next  = enc_shift;
          group_count_next = enc_count;
        end
      end else if (cfg_regs.skip_line_breaks && in_data.in_value == b64sc_pkg::CHAR_LF) begin
        // Skipped line feed: only the end of message matters.
        if (in_data.in_last) begin
          q_push             = 1'b1;
          q_cmd.last         = 1'b1;
          q_cmd.status       = b64sc_pkg::STATUS_TRUNCATED;
          group_bits_next    = '0;
          group_count_next   = '0;
          pad_count_next     = '0;
          bad_char_seen_next = 1'b0;
        end
      end else if (group_count != 2'd3) begin
        // Quartet still open.
        if (in_data.in_last) begin
          q_push             = 1'b1;
          q_cmd.last         = 1'b1;
          q_cmd.status       = b64sc_pkg::STATUS_TRUNCATED;
          group_bits_next    = '0;
          group_count_next   = '0;
          pad_count_next     = '0;
          bad_char_seen_next = 1'b0;
        end else begin
          group_bits_next    = dec_bits;
          group_count_next   = group_count + 2'd1;
          pad_count_next     = pad_n;
          bad_char_seen_next = bad_n;
        end
      end else begin
        // Quartet complete: padding trims the final quartet only.
        bad_fin = bad_n;
        if (!in_data.in_last) begin
          bad_fin = bad_n || (pad_n != 2'd0);
        end else if (pad_n == 2'd3) begin
          bad_fin   = 1'b1;
          nbytes_m1 = 2'd0;
        end else begin
          nbytes_m1 = 2'd2 - pad_n;
        end
        q_push             = 1'b1;
        q_cmd.vals         = {8'd0, dec_bits[7:0], dec_bits[15:8], dec_bits[23:16]};
        q_cmd.last_idx     = nbytes_m1;
        q_cmd.last         = in_data.in_last;
        q_cmd.status       = bad_fin ? b64sc_pkg::STATUS_BAD_CHAR : b64sc_pkg::STATUS_OK;
        group_bits_next    = '0;
        group_count_next   = '0;
        pad_count_next     = '0;
        bad_char_seen_next = 1'b0;
      end
    end
  end

  // Registers and group state; a register write aborts any partial group.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs      <= '0;
      group_bits    <= '0;
      group_count   <= '0;
      pad_count     <= '0;
      bad_char_seen <= 1'b0;
    end else if (cfg_wr.en) begin
      if (cfg_wr.index == b64sc_pkg::REG_DECODE_MODE) begin
        cfg_regs.decode_mode <= cfg_wr.value;
      end else begin
        cfg_regs.skip_line_breaks <= cfg_wr.value;
      end
      group_bits    <= '0;
      group_count   <= '0;
      pad_count     <= '0;
      bad_char_seen <= 1'b0;
    end else begin
      group_bits    <= group_bits_next;
      group_count   <= group_count_next;
      pad_count     <= pad_count_next;
      bad_char_seen <= bad_char_seen_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/b64sc_queue.sv
// Short queue of result groups between the front and back parts.
`default_nettype none
module b64sc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64sc_pkg::cmd_t push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 nonempty,
  output b64sc_pkg::cmd_t      head
);

  b64sc_pkg::cmd_t              entries [b64sc_pkg::QUEUE_DEPTH];
  logic [b64sc_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [b64sc_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [b64sc_pkg::QUEUE_AW:0]   count;

  assign full     = (count == (b64sc_pkg::QUEUE_AW + 1)'(b64sc_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/b64sc_back.sv
// Back part: takes result groups from the queue and sends one item a cycle while the receiver is ready.
`default_nettype none
module b64sc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_nonempty,
  input  wire b64sc_pkg::cmd_t  q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output b64sc_pkg::out_item_t  out_data
);

  b64sc_pkg::cmd_t cur;
  logic [1:0]      idx;
  logic            busy;
  logic            at_end;

  assign at_end = (idx == cur.last_idx);
  assign q_pop  = q_nonempty && (!busy || (out_ready && at_end));

  // Current result item from the held group.
  assign out_valid          = busy;
  assign out_data.out_value = cur.vals[idx];
  assign out_data.out_last  = cur.last && at_end;
  assign out_data.status    = cur.status;

  // Group register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // Sequencing through the held group.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/b64sc_checker.sv
// Port checker for the base64 stream codec and its bind to the top level.
`default_nettype none
`include "base64_stream_codec_unit_assert.svh"
module b64sc_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire b64sc_pkg::out_item_t out_data
);

  logic out_stall;
  logic trunc_item;
  logic trunc_ok;

  // Shorthands for the result channel.
  assign out_stall  = out_valid && !out_ready;
  assign trunc_item = out_valid && out_data.status == b64sc_pkg::STATUS_TRUNCATED;
  assign trunc_ok   = out_data.out_last && out_data.out_value == 8'd0;

  // A stalled result item holds its payload.
  `B64SC_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_data), "stalled item changed")

  // A truncated message reports exactly one zero item that closes it.
  `B64SC_ASSERT(a_trunc_form, trunc_item |-> trunc_ok, "truncation item malformed")

  // Only defined status codes appear.
  `B64SC_ASSERT(a_status_range, out_valid |-> out_data.status <= b64sc_pkg::STATUS_TRUNCATED, "undefined status code")

  // Reset leaves no result pending.
  `B64SC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result item after reset")

endmodule

bind base64_stream_codec_unit b64sc_checker u_checker (.*);
`default_nettype wire

>>> tb/sv/base64_stream_codec_unit_test.sv
// Self-checking testbench for the base64 stream codec, with its own codec predictor.
`default_nettype none
module base64_stream_codec_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Classification codes for one character in decode mode.
  localparam int SEXTET_PAD = 64;
  localparam int SEXTET_BAD = 65;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  b64sc_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  b64sc_pkg::out_item_t out_data;

  // Idle chances in percent, and a long receiver hold-off on request.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;

  // Predictor state: configuration and the group being gathered.
  logic        cfg_decode = 1'b0;
  logic        cfg_skip_lf = 1'b0;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_count = '0;
  logic [1:0]  pad_run = '0;
  logic        bad_seen = 1'b0;

  b64sc_pkg::out_item_t awaited_outputs[$];

  base64_stream_codec_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The 64-character alphabet, built up from character ranges.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    if (s < 6'd26) return 8'h41 + 8'(s);
    if (s < 6'd52) return 8'h61 + 8'(s) - 8'd26;
    if (s < 6'd62) return 8'h30 + 8'(s) - 8'd52;
    if (s == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic int char_to_sextet(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
    if (c == 8'h2B) return 62;
    if (c == 8'h2F) return 63;
    if (c == b64sc_pkg::CHAR_PAD) return SEXTET_PAD;
    return SEXTET_BAD;
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_count = '0;
    pad_run = '0;
    bad_seen = 1'b0;
  endfunction

  function automatic void await_output(input logic [7:0] v, input logic l,
                                       input logic [1:0] st);
    b64sc_pkg::out_item_t r;
    r.out_value = v;
    r.out_last = l;
    r.status = st;
    awaited_outputs.push_back(r);
  endfunction

  // Works out the results that one accepted item causes.
  function automatic void b64_transcode(input b64sc_pkg::in_item_t it);
    logic [23:0] bits;
    int          nres;
    int          s;
    logic [1:0]  st;
    if (!cfg_decode) begin
      grp_bits = {grp_bits[15:0], it.in_value};
      grp_count = grp_count + 2'd1;
      if (grp_count == 2'd3) begin
        bits = grp_bits;
        nres = 4;
      end else if (it.in_last) begin
        bits = (grp_count == 2'd1) ? {grp_bits[7:0], 16'h0} : {grp_bits[15:0], 8'h0};
        nres = int'(grp_count) + 1;
      end else begin
        return;
      end
      for (int i = 0; i < 4; i++) begin
        await_output((i < nres) ? sextet_to_char(bits[18 - 6 * i +: 6]) :
                                  b64sc_pkg::CHAR_PAD,
                     it.in_last && i == 3, b64sc_pkg::STATUS_OK);
      end
      clear_group();
      return;
    end
    // Decode: a skipped line feed only matters when it ends the message.
    if (cfg_skip_lf && it.in_value == b64sc_pkg::CHAR_LF) begin
      if (!it.in_last) return;
      clear_group();
      await_output(8'h00, 1'b1, b64sc_pkg::STATUS_TRUNCATED);
      return;
    end
    s = char_to_sextet(it.in_value);
    if (s == SEXTET_PAD) begin
      if (pad_run != 2'd3) pad_run = pad_run + 2'd1;
      s = 0;
    end else begin
      if (s == SEXTET_BAD) begin
        bad_seen = 1'b1;
        s = 0;
      end
      if (pad_run != 2'd0) bad_seen = 1'b1;
      pad_run = '0;
    end
    grp_bits = {grp_bits[17:0], 6'(s)};
    if (grp_count != 2'd3) begin
      grp_count = grp_count + 2'd1;
      if (!it.in_last) return;
      clear_group();
      await_output(8'h00, 1'b1, b64sc_pkg::STATUS_TRUNCATED);
      return;
    end
    if (!it.in_last) begin
      if (pad_run != 2'd0) bad_seen = 1'b1;
      nres = 3;
    end else if (pad_run == 2'd3) begin
      bad_seen = 1'b1;
      nres = 1;
    end else begin
      nres = 3 - int'(pad_run);
    end
    st = bad_seen ? b64sc_pkg::STATUS_BAD_CHAR : b64sc_pkg::STATUS_OK;
    for (int i = 0; i < nres; i++) begin
      await_output(grp_bits[16 - 8 * i +: 8], it.in_last && i + 1 == nres, st);
    end
    clear_group();
  endfunction

  // Receiver: random stalls, plus a long hold-off counted here when asked for.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares every accepted result with the oldest awaited one.
  always @(posedge clk) begin : check_results
    b64sc_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_outputs.size() == 0) begin
        $error("unexpected result: out_value %0h out_last %0b status %0d",
               out_data.out_value, out_data.out_last, out_data.status);
        fail_count++;
      end else begin
        want = awaited_outputs.pop_front();
        if (out_data.out_value !== want.out_value) begin
          $error("out_value: expected %0h, got %0h", want.out_value, out_data.out_value);
          fail_count++;
        end
        if (out_data.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, out_data.out_last);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // Offers one item, idling first at random, and predicts once it is taken.
  task automatic send_item(input logic [7:0] v, input logic l);
    b64sc_pkg::in_item_t it;
    it.in_value = v;
    it.in_last = l;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    b64_transcode(it);
    items_sent++;
  endtask

  // Waits until every awaited result has arrived and the block has settled.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(input logic idx, input logic val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {31'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == b64sc_pkg::REG_DECODE_MODE) cfg_decode = val;
    else cfg_skip_lf = val;
    clear_group();
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], last_at_end && i == s.len() - 1);
    end
  endtask

  task automatic send_byte_message(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(8'($urandom_range(255)), i == n - 1);
    end
  endtask

  // Proper base64 text of n random bytes; damage 1 corrupts one character,
  // damage 2 cuts the final character so that the last quartet is short.
  task automatic send_encoded_text(input int n, input bit breaks, input int damage);
    logic [7:0]  text[$];
    logic [23:0] g;
    int          take;
    for (int i = 0; i < n; i += 3) begin
      take = (n - i >= 3) ? 3 : n - i;
      g = 24'($urandom);
      if (take == 1) g[15:0] = '0;
      if (take == 2) g[7:0] = '0;
      for (int k = 0; k < 4; k++) begin
        text.push_back((k <= take) ? sextet_to_char(g[18 - 6 * k +: 6]) :
                                     b64sc_pkg::CHAR_PAD);
      end
    end
    if (damage == 1) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
    else if (damage == 2) void'(text.pop_back());
    for (int i = 0; i < text.size(); i++) begin
      if (breaks && $urandom_range(7) == 0) send_item(b64sc_pkg::CHAR_LF, 1'b0);
      send_item(text[i], i == text.size() - 1);
    end
  endtask

  // Character soup biased towards the alphabet, padding and line feeds.
  task automatic send_noise(input int n);
    int          pick;
    logic [7:0]  c;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) c = 8'($urandom_range(255));
      else if (pick < 75) c = sextet_to_char(6'($urandom_range(63)));
      else if (pick < 90) c = b64sc_pkg::CHAR_PAD;
      else c = b64sc_pkg::CHAR_LF;
      send_item(c, i == n - 1);
    end
  endtask

  // Encoding at the byte extremes, with full groups and both partial endings.
  task automatic test_encode_edges();
    wait_quiet();
    reg_write(b64sc_pkg::REG_DECODE_MODE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b1);
  endtask

  // Decoding: symbol characters, data after padding, an unskipped line feed,
  // padding in a quartet that is not final, and three pads at the end.
  task automatic test_decode_specials();
    wait_quiet();
    reg_write(b64sc_pkg::REG_DECODE_MODE, 1'b1);
    reg_write(b64sc_pkg::REG_SKIP_LF, 1'b0);
    send_text("+/09", 1'b0);
    send_text("A=z\n", 1'b0);
    send_text("QQ==", 1'b0);
    send_text("Q===", 1'b1);
  endtask

  // Skipped line feeds inside a message and alone at its end, and a short tail.
  task automatic test_line_feed_skip();
    wait_quiet();
    reg_write(b64sc_pkg::REG_SKIP_LF, 1'b1);
    send_text("Zm\n9=", 1'b1);
    send_text("\n", 1'b1);
    send_text("AB", 1'b1);
  endtask

  // A register write drops a partly gathered group.
  task automatic test_config_abort();
    wait_quiet();
    reg_write(b64sc_pkg::REG_DECODE_MODE, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'hBB, 1'b0);
    wait_quiet();
    reg_write(b64sc_pkg::REG_SKIP_LF, 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  // The receiver holds off for a long stretch while bytes keep coming.
  task automatic test_output_backpressure();
    wait_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(b64sc_pkg::REG_DECODE_MODE, 1'b0);
    hold_request = 200;
    send_byte_message(30);
  endtask

  // Random encode messages, then mostly proper decode text with some damage.
  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                     input logic skip);
    int unsigned goal;
    int          pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    wait_quiet();
    reg_write(b64sc_pkg::REG_DECODE_MODE, 1'b0);
    goal = items_sent + 18;
    while (items_sent < goal) send_byte_message($urandom_range(1, 9));
    wait_quiet();
    reg_write(b64sc_pkg::REG_DECODE_MODE, 1'b1);
    reg_write(b64sc_pkg::REG_SKIP_LF, skip);
    goal = items_sent + 25;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) send_encoded_text($urandom_range(1, 6), skip, 0);
      else if (pick < 85) send_encoded_text($urandom_range(1, 6), skip, 1);
      else if (pick < 90) send_encoded_text($urandom_range(1, 6), skip, 2);
      else send_noise($urandom_range(1, 9));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_edges();
    test_decode_specials();
    test_line_feed_skip();
    test_config_abort();
    test_random_traffic(23, 68, 1'b1);
    test_random_traffic(68, 23, 1'b0);
    test_random_traffic(0, 0, 1'b1);
    test_output_backpressure();
    wait_quiet();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
